[design/bocv_pkg.sv]
package bocv_pkg;

  // Table geometry and percentage steps
  localparam int TableEntries = 11;
  localparam int StepPct      = 10;
  localparam int FullPct      = 100;

  // Widths for the top level and the serial divider
  localparam int MvW    = 16;
  localparam int StepsW = 5;
  localparam int PctW   = 7;

  // Operation codes carried in tuser of the input stream
  localparam logic OpConvert = 1'b0;
  localparam logic OpLoad    = 1'b1;

  // Step counts for the two uses of the divider
  localparam logic [StepsW-1:0] StepsCell   = StepsW'(16);
  localparam logic [StepsW-1:0] StepsInterp = StepsW'(4);

  // Request from the sequencer to the divider
  typedef struct packed {
    logic              start;
    logic [StepsW-1:0] steps;
  } div_req_t;

endpackage

[design/bocv_div.sv]
module bocv_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bocv_pkg::div_req_t        req_i,
  input  logic [bocv_pkg::MvW-1:0]  rem_init_i,
  input  logic [bocv_pkg::MvW-1:0]  num_i,
  input  logic [bocv_pkg::MvW-1:0]  den_i,
  output logic                      done_o,
  output logic [bocv_pkg::MvW-1:0]  quot_o
);
  import bocv_pkg::*;

  logic [MvW-1:0]    rem_q, rem_d;
  logic [MvW-1:0]    num_q, num_d;
  logic [MvW-1:0]    den_q, den_d;
  logic [MvW-1:0]    quot_q, quot_d;
  logic [StepsW-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [MvW:0]      trial;
  logic [MvW:0]      diff;
  logic              fits;

  // One restoring step: bring down the next numerator bit, try the subtract
  assign trial = {rem_q, num_q[MvW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    den_d  = den_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = rem_init_i;
      num_d  = num_i;
      den_d  = den_i;
      quot_d = '0;
      cnt_d  = req_i.steps;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? diff[MvW-1:0] : trial[MvW-1:0];
      num_d  = {num_q[MvW-2:0], 1'b0};
      quot_d = {quot_q[MvW-2:0], fits};
      cnt_d  = cnt_q - StepsW'(1);
      if (cnt_q == StepsW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    num_q  <= num_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[design/battery_ocv_percent_interp.sv]
// Channel   | Direction | Transfer carries
// s_axis    | in        | tuser: operation; tdata: pack mV, entry index, entry mV
// m_axis    | out       | tuser: error; tdata: percent
// cfg_wr    | in        | cells in series, registered, no read-back
//
// A table load is written when accepted. A conversion runs the per-cell division
// (radix-2 serial divider, one quotient bit per cycle, skipped when the cell
// count is 0 or 1), scans one table entry per cycle through the segments, then
// interpolates through the same divider and hands the result over.
// Reset clears the control state and sets cells in series to 1; the table holds
// nothing until loaded. A result waits in the output register while the next
// transfer is accepted; a stalled output holds the sequencer at its last step.
module battery_ocv_percent_interp #(
  parameter int TABLE_ENTRIES = bocv_pkg::TableEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // [15:0] pack mV, [19:16] entry index, [35:20] entry mV
  input  logic [0:0]  s_axis_tuser,  // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [6:0] percent
  output logic [0:0]  m_axis_tuser,  // [0] error
  input  logic        cfg_wr_en_i,
  input  logic [3:0]  cfg_wr_data_i
);
  import bocv_pkg::*;

  localparam int IdxW = $clog2(TABLE_ENTRIES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_SCAN,
    S_INTERP,
    S_EMIT
  } state_e;

  state_e           state_q, state_d;
  logic [MvW-1:0]   tbl_q [TABLE_ENTRIES];
  logic [3:0]       cells_q, cells_d;
  logic [MvW-1:0]   v_q, v_d;
  logic [MvW-1:0]   hi_q, hi_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [PctW-1:0]  pct_low_q, pct_low_d;
  logic [PctW-1:0]  res_pct_q, res_pct_d;
  logic             res_err_q, res_err_d;
  logic             out_valid_q, out_valid_d;
  logic [PctW-1:0]  out_pct_q, out_pct_d;
  logic             out_err_q, out_err_d;

  logic             in_xfer;
  logic [MvW-1:0]   in_pack_mv;
  logic [3:0]       in_index;
  logic [MvW-1:0]   in_entry_mv;
  logic             in_op;
  logic [MvW-1:0]   lo;
  logic [MvW-1:0]   dv;
  logic [MvW-1:0]   dlo;
  logic [19:0]      scaled;
  div_req_t         div_req;
  logic [MvW-1:0]   div_rem_init;
  logic [MvW-1:0]   div_num;
  logic [MvW-1:0]   div_den;
  logic             div_done;
  logic [MvW-1:0]   div_quot;

  // Input unpacking
  assign in_pack_mv  = s_axis_tdata[15:0];
  assign in_index    = s_axis_tdata[19:16];
  assign in_entry_mv = s_axis_tdata[35:20];
  assign in_op       = s_axis_tuser[0];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Segment arithmetic: 10 * (v - lo) as x*8 + x*2
  assign lo     = tbl_q[idx_q];
  assign dv     = hi_q - lo;
  assign dlo    = v_q - lo;
  assign scaled = 20'({dlo, 3'b000}) + 20'({dlo, 1'b0});

  bocv_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .rem_init_i (div_rem_init),
    .num_i      (div_num),
    .den_i      (div_den),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Sequencer
  always_comb begin
    state_d      = state_q;
    cells_d      = cells_q;
    v_d          = v_q;
    hi_d         = hi_q;
    idx_d        = idx_q;
    pct_low_d    = pct_low_q;
    res_pct_d    = res_pct_q;
    res_err_d    = res_err_q;
    out_valid_d  = out_valid_q;
    out_pct_d    = out_pct_q;
    out_err_d    = out_err_q;
    div_req      = '{start: 1'b0, steps: StepsCell};
    div_rem_init = '0;
    div_num      = in_pack_mv;
    div_den      = {{(MvW - 4){1'b0}}, cells_q};

    if (cfg_wr_en_i) begin
      cells_d = cfg_wr_data_i;
    end
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer && in_op == OpConvert) begin
          v_d = in_pack_mv;
          if (cells_q > 4'd1) begin
            div_req.start = 1'b1;
            state_d       = S_DIV;
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          v_d     = div_quot;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        res_pct_d = '0;
        res_err_d = 1'b0;
        if (v_q == '0) begin
          res_err_d = 1'b1;
          state_d   = S_EMIT;
        end else if (v_q >= tbl_q[0]) begin
          res_pct_d = PctW'(FullPct);
          state_d   = S_EMIT;
        end else if (v_q <= tbl_q[LastIdx]) begin
          state_d = S_EMIT;
        end else begin
          hi_d      = tbl_q[0];
          idx_d     = IdxW'(1);
          pct_low_d = PctW'(FullPct - StepPct);
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (v_q <= hi_q && v_q >= lo) begin
          if (dv == '0) begin
            res_pct_d = pct_low_q;
            state_d   = S_EMIT;
          end else begin
            // quotient stays below 16, so the top 16 bits preload the remainder
            div_req      = '{start: 1'b1, steps: StepsInterp};
            div_rem_init = scaled[19:4];
            div_num      = {scaled[3:0], {(MvW - 4){1'b0}}};
            div_den      = dv;
            state_d      = S_INTERP;
          end
        end else if (idx_q == LastIdx) begin
          res_err_d = 1'b1;
          state_d   = S_EMIT;
        end else begin
          hi_d      = lo;
          idx_d     = idx_q + IdxW'(1);
          pct_low_d = pct_low_q - PctW'(StepPct);
        end
      end
      S_INTERP: begin
        if (div_done) begin
          res_pct_d = pct_low_q + PctW'(div_quot[3:0]);
          state_d   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_pct_d   = res_pct_q;
          out_err_d   = res_err_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cells_q     <= 4'd1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cells_q     <= cells_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    v_q       <= v_d;
    hi_q      <= hi_d;
    idx_q     <= idx_d;
    pct_low_q <= pct_low_d;
    res_pct_q <= res_pct_d;
    res_err_q <= res_err_d;
    out_pct_q <= out_pct_d;
    out_err_q <= out_err_d;
  end

  // OCV table; out-of-range loads are dropped
  always_ff @(posedge clk_i) begin
    if (in_xfer && in_op == OpLoad && 32'(in_index) < TABLE_ENTRIES) begin
      tbl_q[in_index[IdxW-1:0]] <= in_entry_mv;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_pct_q};
  assign m_axis_tuser  = out_err_q;

endmodule

[tb/battery_ocv_percent_interp_test.sv]
`timescale 1ns / 1ps

module battery_ocv_percent_interp_test;
  import bocv_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int HoldOffCycles = 300;
  localparam int DrainCycles   = 40;
  localparam int NumPhases     = 10;
  localparam int ItemsPerPhase = 103;

  typedef struct packed {
    logic [PctW-1:0] percent;
    logic            error;
  } soc_result_t;

  // Shadow of the table and cell count, plus the queue of charge readings still owed
  class soc_scoreboard;
    logic [MvW-1:0] ocv_mv [TableEntries];
    logic [3:0]     cells;
    soc_result_t    soc_expected [$];
    int             n_fail;
    int             n_conv;
    int             n_load;
    int             n_flagged;

    function new();
      cells = 4'd1;
      foreach (ocv_mv[i]) ocv_mv[i] = '0;
      n_fail    = 0;
      n_conv    = 0;
      n_load    = 0;
      n_flagged = 0;
    endfunction

    // Per-cell voltage, then clamp at the ends or interpolate in the first bracketing segment
    function soc_result_t predict_soc(input logic [MvW-1:0] pack_mv);
      int unsigned v;
      int unsigned hi;
      int unsigned lo;
      int unsigned dv;
      int unsigned pct;
      soc_result_t r;
      r = '0;
      v = pack_mv;
      if (cells > 4'd1) v = v / cells;
      if (v == 0) begin
        r.error = 1'b1;
        return r;
      end
      if (v >= ocv_mv[0]) begin
        r.percent = PctW'(FullPct);
        return r;
      end
      if (v <= ocv_mv[TableEntries-1]) return r;
      for (int i = 0; i < TableEntries - 1; i++) begin
        hi = ocv_mv[i];
        lo = ocv_mv[i+1];
        if (v <= hi && v >= lo) begin
          pct = FullPct - (i + 1) * StepPct;
          dv  = hi - lo;
          if (dv != 0) pct = pct + ((v - lo) * StepPct) / dv;
          if (pct > FullPct) pct = FullPct;
          r.percent = pct[PctW-1:0];
          return r;
        end
      end
      r.error = 1'b1;
      return r;
    endfunction

    function void note_input(input logic op, input logic [MvW-1:0] pack_mv,
                             input logic [3:0] idx, input logic [MvW-1:0] entry_mv);
      soc_result_t r;
      if (op == OpLoad) begin
        // slots past the table are dropped
        if (idx < TableEntries) begin
          ocv_mv[idx] = entry_mv;
          n_load++;
        end
      end else begin
        r = predict_soc(pack_mv);
        soc_expected.push_back(r);
        n_conv++;
        if (r.error) n_flagged++;
      end
    endfunction

    function void check_result(input logic [PctW-1:0] pct, input logic err);
      soc_result_t want;
      if (soc_expected.size() == 0) begin
        $error("unexpected result: percent %0d, error %0d", pct, err);
        n_fail++;
        return;
      end
      want = soc_expected.pop_front();
      if (want.percent !== pct) begin
        $error("percent: expected %0d, actual %0d", want.percent, pct);
        n_fail++;
      end
      if (want.error !== err) begin
        $error("error: expected %0d, actual %0d", want.error, err);
        n_fail++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_wr_en_i;
  logic [3:0]  cfg_wr_data_i;

  soc_scoreboard sb;
  bit            idle_on;
  bit            hold_off_req;
  int            settings_used;

  battery_ocv_percent_interp u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Input transfers update the shadow state, output transfers are checked
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      sb.note_input(s_axis_tuser[0], s_axis_tdata[15:0], s_axis_tdata[19:16],
                    s_axis_tdata[35:20]);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata[PctW-1:0], m_axis_tuser[0]);
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin : sink
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Give up if no transfer happens on either side for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("battery_ocv_percent_interp_test: done, errors");
    $finish;
  end

  // Offer one item, with an optional gap first, and hold it until the transfer
  task automatic send_item(input logic op, input logic [MvW-1:0] pack_mv,
                           input logic [3:0] idx, input logic [MvW-1:0] entry_mv);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, entry_mv, idx, pack_mv};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
  endtask

  // All readings in, then let any trailing load settle; the first edge lets the
  // last accepted transfer reach the scoreboard
  task automatic await_idle();
    @(posedge clk_i);
    while (sb.soc_expected.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cells(input logic [3:0] n);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= n;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    sb.cells = n;
    settings_used++;
  endtask

  // Whole table: mostly a falling curve scaled to the divisor, sometimes raw noise
  task automatic load_table(input int d);
    logic [MvW-1:0] mv [TableEntries];
    int step;
    if ($urandom_range(0, 4) == 0) begin
      foreach (mv[i]) mv[i] = 16'($urandom);
    end else begin
      mv[0] = 16'($urandom_range(200, 65535 / d));
      for (int i = 1; i < TableEntries; i++) begin
        if ($urandom_range(0, 5) == 0) step = 0;
        else step = $urandom_range(1, mv[i-1] / 8 + 1);
        mv[i] = (step > mv[i-1]) ? '0 : mv[i-1] - 16'(step);
      end
    end
    for (int i = 0; i < TableEntries; i++) send_item(OpLoad, 16'($urandom), 4'(i), mv[i]);
  endtask

  task automatic run_directed();
    logic [MvW-1:0] base [TableEntries];
    // typical single-cell curve with one flat pair
    base = '{16'd4200, 16'd4060, 16'd3980, 16'd3920, 16'd3870, 16'd3820,
             16'd3820, 16'd3770, 16'd3740, 16'd3680, 16'd3300};
    for (int i = 0; i < TableEntries; i++) send_item(OpLoad, 16'hFFFF, 4'(i), base[i]);
    // slots past the table
    send_item(OpLoad, 16'h0000, 4'd11, 16'hFFFF);
    send_item(OpLoad, 16'hFFFF, 4'd15, 16'h0000);
    // zero voltage, ends of the table, interpolation, flat pair
    send_item(OpConvert, 16'h0000, 4'd0, 16'h0000);
    send_item(OpConvert, 16'hFFFF, 4'hF, 16'hFFFF);
    send_item(OpConvert, 16'd4200, 4'd0, 16'h0000);
    send_item(OpConvert, 16'd3300, 4'd0, 16'h0000);
    send_item(OpConvert, 16'd1, 4'd0, 16'h0000);
    send_item(OpConvert, 16'd4199, 4'd0, 16'h0000);
    send_item(OpConvert, 16'd4061, 4'd0, 16'h0000);
    send_item(OpConvert, 16'd3775, 4'd0, 16'h0000);
    send_item(OpConvert, 16'd3820, 4'd0, 16'h0000);
  endtask

  task automatic run_random_phase(input int n_items);
    int done;
    int pick;
    int seg;
    int d;
    int v;
    int pack;
    done = 0;
    d = (sb.cells > 4'd1) ? int'(sb.cells) : 1;
    load_table(d);
    done += TableEntries;
    while (done < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        load_table(d);
        done += TableEntries;
      end else if (pick < 8) begin
        // ignored load, does not count
        send_item(OpLoad, 16'($urandom), 4'($urandom_range(11, 15)), 16'($urandom));
      end else if (pick < 12) begin
        send_item(OpLoad, 16'($urandom), 4'($urandom_range(0, 10)), 16'($urandom));
        done++;
      end else if (pick < 24) begin
        send_item(OpConvert, 16'($urandom), 4'($urandom), 16'($urandom));
        done++;
      end else begin
        seg = $urandom_range(0, 13);
        if (seg < TableEntries - 1) v = $urandom_range(sb.ocv_mv[seg+1], sb.ocv_mv[seg]);
        else if (seg == 10) v = sb.ocv_mv[$urandom_range(0, 10)];
        else if (seg == 11) v = sb.ocv_mv[0] + $urandom_range(0, 3);
        else if (seg == 12) v = int'(sb.ocv_mv[TableEntries-1]) - $urandom_range(0, 3);
        else v = 0;
        pack = v * d + $urandom_range(0, d - 1);
        if (pack > 65535) pack = 65535;
        if (pack < 0) pack = 0;
        send_item(OpConvert, 16'(pack), 4'($urandom), 16'($urandom));
        done++;
      end
    end
  endtask

  initial begin : main
    logic [3:0] cell_setting;
    sb = new();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_wr_en_i   <= 1'b0;
    cfg_wr_data_i <= '0;
    idle_on       = 1'b1;
    hold_off_req  = 1'b0;
    settings_used = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    // one cell count per phase: 1, 8, 0 and 15 first, then random
    for (int p = 0; p < NumPhases; p++) begin
      stop_sending();
      await_idle();
      case (p)
        0:       cell_setting = 4'd1;
        1:       cell_setting = 4'd8;
        2:       cell_setting = 4'd0;
        3:       cell_setting = 4'd15;
        default: cell_setting = 4'($urandom_range(0, 15));
      endcase
      write_cells(cell_setting);
      if (p == 2) hold_off_req = 1'b1;
      if (p >= NumPhases - 2) idle_on = 1'b0;
      run_random_phase(ItemsPerPhase);
    end

    stop_sending();
    await_idle();
    $display("Checked %0d conversions (%0d flagged) and %0d table loads over %0d cell counts,",
             sb.n_conv, sb.n_flagged, sb.n_load, settings_used);
    $display("with random stalls on both sides and one long output hold-off.");
    if (sb.n_fail == 0) begin
      $display("battery_ocv_percent_interp_test: done, clean");
    end else begin
      $display("battery_ocv_percent_interp_test: done, errors");
    end
    $finish;
  end

endmodule
